// File: rtl/gtfa_pkg.sv
// Shared types and constants for the GB2312 text to font ROM address unit.
// No dependencies.
`default_nettype none
package gtfa_pkg;

    localparam logic [7:0] HANZI_LEAD_LO = 8'hB0;
    localparam logic [7:0] HANZI_LEAD_HI = 8'hF7;
    localparam logic [7:0] SYM_LEAD_LO   = 8'hA1;
    localparam logic [7:0] SYM_LEAD_HI   = 8'hA3;
    localparam logic [7:0] TRAIL_LO      = 8'hA1;
    localparam logic [7:0] ASCII_LO      = 8'h20;
    localparam logic [7:0] ASCII_HI      = 8'h7E;
    localparam logic [7:0] TERMINATOR    = 8'h00;
    localparam logic [7:0] WIDE_STEP     = 8'd16;
    localparam logic [7:0] NARROW_STEP   = 8'd8;

    localparam logic [12:0] ROW_SIZE     = 13'd94;
    localparam logic [12:0] HANZI_OFFSET = 13'd846;
    localparam logic [7:0]  PAGE_CMD     = 8'hB0;
    localparam logic [4:0]  COL_HI_CMD   = 5'h10;

    localparam int          ADDR_W       = 24;
    localparam logic [ADDR_W-1:0] ASCII_BASE_RESET = 24'h03CF80;

    localparam int          PADDR_W      = 3;
    localparam logic [PADDR_W-1:0] REG_HANZI_BASE = 3'd0;
    localparam logic [PADDR_W-1:0] REG_ASCII_BASE = 3'd4;

    typedef struct packed {
        logic       wide;
        logic       sym;
        logic [6:0] lead_off;
        logic [6:0] char_off;
        logic [7:0] column;
        logic [3:0] page;
    } t_job;

endpackage
`default_nettype wire

// File: rtl/gtfa_front.sv
// Front end: takes text bytes, tracks lead byte, page and column, emits glyph jobs.
// Depends on gtfa_pkg.
`default_nettype none
module gtfa_front import gtfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_first_of_string,
    input  wire logic [3:0] i_start_page,
    input  wire logic [7:0] i_start_column,
    output logic            o_push,
    output t_job            o_job
);

    logic [7:0] r_lead, n_lead;
    logic       r_pend, n_pend;
    logic [7:0] r_col,  n_col;
    logic [3:0] r_page, n_page;
    logic       r_ended, n_ended;

    logic [7:0] w_col;
    logic [3:0] w_page;
    logic       w_pend;
    logic       w_live;
    logic       w_is_lead;
    logic       w_is_ascii;
    logic       w_lead_sym;

    always_comb begin
        w_col      = i_first_of_string ? i_start_column : r_col;
        w_page     = i_first_of_string ? i_start_page : r_page;
        w_pend     = i_first_of_string ? 1'b0 : r_pend;
        w_live     = i_first_of_string || !r_ended;
        w_is_lead  = (i_text_byte >= HANZI_LEAD_LO && i_text_byte <= HANZI_LEAD_HI) ||
                     (i_text_byte >= SYM_LEAD_LO && i_text_byte <= SYM_LEAD_HI);
        w_is_ascii = i_text_byte >= ASCII_LO && i_text_byte <= ASCII_HI;
        w_lead_sym = r_lead < HANZI_LEAD_LO;

        n_lead  = r_lead;
        n_pend  = r_pend;
        n_col   = r_col;
        n_page  = r_page;
        n_ended = r_ended;
        o_push  = 1'b0;

        o_job.wide     = 1'b0;
        o_job.sym      = w_lead_sym;
        o_job.lead_off = w_lead_sym ? 7'(r_lead - SYM_LEAD_LO) : 7'(r_lead - HANZI_LEAD_LO);
        o_job.char_off = 7'(i_text_byte - ASCII_LO);
        o_job.column   = w_col;
        o_job.page     = w_page;

        if (i_accept && w_live) begin
            n_page  = w_page;
            n_col   = w_col;
            n_ended = 1'b0;
            n_pend  = 1'b0;
            if (w_pend && i_text_byte >= TRAIL_LO) begin
                o_push         = 1'b1;
                o_job.wide     = 1'b1;
                o_job.char_off = 7'(i_text_byte - TRAIL_LO);
                n_col          = w_col + WIDE_STEP;
            end else if (i_text_byte == TERMINATOR) begin
                n_ended = 1'b1;
            end else if (w_is_lead) begin
                n_lead = i_text_byte;
                n_pend = 1'b1;
            end else if (w_is_ascii) begin
                o_push = 1'b1;
                n_col  = w_col + NARROW_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead <= n_lead;
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_col   <= 8'd0;
            r_page  <= 4'd1;
            r_ended <= 1'b1;
        end else begin
            r_pend  <= n_pend;
            r_col   <= n_col;
            r_page  <= n_page;
            r_ended <= n_ended;
        end
    end

    a_idle_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_first_of_string && r_ended) |-> !o_push)
        else $error("glyph emitted while string ended");

    a_wide_needs_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.wide) |-> (r_pend && !i_first_of_string))
        else $error("wide glyph without held lead byte");

endmodule
`default_nettype wire

// File: rtl/gtfa_queue.sv
// Small FIFO of glyph jobs between front and back ends.
// Depends on gtfa_pkg.
`default_nettype none
module gtfa_queue import gtfa_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/gtfa_back.sv
// Back end: turns a glyph job into a font ROM address and controller commands.
// Depends on gtfa_pkg.
`default_nettype none
module gtfa_back import gtfa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  wire t_job              i_job,
    output logic                   o_pop,
    input  wire logic [ADDR_W-1:0] i_hanzi_base,
    input  wire logic [ADDR_W-1:0] i_ascii_base,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ADDR_W-1:0]      o_glyph_address,
    output logic                   o_wide_glyph,
    output logic [7:0]             o_glyph_column,
    output logic [7:0]             o_page_command,
    output logic [4:0]             o_column_high_command,
    output logic [3:0]             o_column_low_command
);

    logic              r_valid;
    logic [12:0]       w_idx;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_c;

    assign o_pop = i_job_valid && (!r_valid || i_out_ready);

    always_comb begin
        w_idx = 13'(i_job.lead_off) * ROW_SIZE + 13'(i_job.char_off) +
                (i_job.sym ? 13'd0 : HANZI_OFFSET);
        if (i_job.wide) begin
            w_addr = ADDR_W'({w_idx, 5'b0}) + i_hanzi_base;
        end else begin
            w_addr = ADDR_W'({i_job.char_off, 4'b0}) + i_ascii_base;
        end
        w_c = i_job.column - 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_glyph_address       <= w_addr;
            o_wide_glyph          <= i_job.wide;
            o_glyph_column        <= i_job.column;
            o_page_command        <= PAGE_CMD + {4'b0, i_job.page} - 8'd1;
            o_column_high_command <= COL_HI_CMD + {1'b0, w_c[7:4]};
            o_column_low_command  <= w_c[3:0];
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;

endmodule
`default_nettype wire

// File: rtl/gb2312_text_to_font_rom_address_unit.sv
// GB2312 text to font ROM address unit, top level.
// Text bytes come in on the input channel; each printable ASCII byte or
// GB2312 lead/trail pair gives one word on the output channel: the font
// ROM address, glyph width, start column and the page/column command bytes
// for the display controller.
// Set i_first_of_string on the first byte to load start page and column;
// byte 0 ends the string. Lead bytes and control bytes give no word.
// Base addresses sit in an APB register file (0x0 hanzi, 0x4 ASCII).
// A glyph word is queued at the edge that takes its last byte and then
// registered in the back end from the queue, which holds it while the
// output register is full and the receiver stalls.
// Throughput: one byte per cycle while o_in_ready is high; the constant
// multiply by 94 and the base add are combinational in the back end.
// When the receiver stalls, the output register holds and the job queue
// (QUEUE_DEPTH entries) fills, then o_in_ready drops.
// Reset drops any held lead, sets page 1, column 0 and idles until a first byte;
// hanzi base resets to 0, ASCII base to 0x3CF80. No clearing pass.
// Depends on gtfa_pkg, gtfa_front, gtfa_queue, gtfa_back.
`default_nettype none
module gb2312_text_to_font_rom_address_unit import gtfa_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_text_byte,
    input  wire logic               i_first_of_string,
    input  wire logic [3:0]         i_start_page,
    input  wire logic [7:0]         i_start_column,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [ADDR_W-1:0]       o_glyph_address,
    output logic                    o_wide_glyph,
    output logic [7:0]              o_glyph_column,
    output logic [7:0]              o_page_command,
    output logic [4:0]              o_column_high_command,
    output logic [3:0]              o_column_low_command,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [ADDR_W-1:0] r_hanzi_base;
    logic [ADDR_W-1:0] r_ascii_base;
    logic              w_wr;
    logic              w_accept;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    t_job              w_front_job;
    t_job              w_queue_job;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            REG_HANZI_BASE: prdata = {8'b0, r_hanzi_base};
            REG_ASCII_BASE: prdata = {8'b0, r_ascii_base};
            default:        prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hanzi_base <= '0;
            r_ascii_base <= ASCII_BASE_RESET;
        end else if (w_wr) begin
            if (paddr == REG_HANZI_BASE) begin
                r_hanzi_base <= pwdata[ADDR_W-1:0];
            end
            if (paddr == REG_ASCII_BASE) begin
                r_ascii_base <= pwdata[ADDR_W-1:0];
            end
        end
    end

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    gtfa_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_text_byte       (i_text_byte),
        .i_first_of_string (i_first_of_string),
        .i_start_page      (i_start_page),
        .i_start_column    (i_start_column),
        .o_push            (w_push),
        .o_job             (w_front_job)
    );

    gtfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_queue_job)
    );

    gtfa_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_job_valid           (!w_empty),
        .i_job                 (w_queue_job),
        .o_pop                 (w_pop),
        .i_hanzi_base          (r_hanzi_base),
        .i_ascii_base          (r_ascii_base),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_glyph_address       (o_glyph_address),
        .o_wide_glyph          (o_wide_glyph),
        .o_glyph_column        (o_glyph_column),
        .o_page_command        (o_page_command),
        .o_column_high_command (o_column_high_command),
        .o_column_low_command  (o_column_low_command)
    );

endmodule
`default_nettype wire

// File: dv/gb2312_text_to_font_rom_address_unit_test.sv
`timescale 1ns / 1ps
// Testbench for gb2312_text_to_font_rom_address_unit: a directed byte table, then random
// strings across several base-address settings, checked against a local glyph predictor.
// Depends on gtfa_pkg and the RTL of the unit.
module gb2312_text_to_font_rom_address_unit_test;
    import gtfa_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wide;
        logic [7:0]        column;
        logic [7:0]        page_cmd;
        logic [4:0]        col_hi;
        logic [3:0]        col_lo;
    } t_glyph;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_GLYPH} t_row_kind;

    typedef struct packed {
        logic [7:0] text;
        logic       first;
        logic [3:0] page;
        logic [7:0] column;
        t_row_kind  kind;
        t_glyph     glyph;
    } t_text_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] text_byte = '0;
    logic first_of_string = 1'b0;
    logic [3:0] start_page = '0;
    logic [7:0] start_column = '0;
    logic out_ready = 1'b1;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire [31:0] prdata;
    wire pready;
    wire in_ready;
    wire out_valid;
    wire [ADDR_W-1:0] glyph_address;
    wire wide_glyph;
    wire [7:0] glyph_column;
    wire [7:0] page_command;
    wire [4:0] column_high_command;
    wire [3:0] column_low_command;

    gb2312_text_to_font_rom_address_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_text_byte           (text_byte),
        .i_first_of_string     (first_of_string),
        .i_start_page          (start_page),
        .i_start_column        (start_column),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_glyph_address       (glyph_address),
        .o_wide_glyph          (wide_glyph),
        .o_glyph_column        (glyph_column),
        .o_page_command        (page_command),
        .o_column_high_command (column_high_command),
        .o_column_low_command  (column_low_command),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [ADDR_W-1:0] hanzi_base = '0;
    logic [ADDR_W-1:0] ascii_base = ASCII_BASE_RESET;
    logic [7:0] held_lead = '0;
    bit lead_held = 1'b0;
    logic [7:0] col_now = '0;
    logic [3:0] page_now = 4'd1;
    bit str_done = 1'b1;

    t_glyph glyphs_due[$];
    int mismatches = 0;
    int live_bytes = 0;
    int idle_cycles = 0;
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    bit open_string = 1'b0;
    logic [3:0] string_page;
    logic [7:0] string_column;
    t_text_row script [26];

    function automatic t_glyph glyph_of(input logic [ADDR_W-1:0] a, input logic w);
        logic [7:0] c;
        c = col_now - 8'd1;
        glyph_of = '{a, w, col_now, 8'(PAGE_CMD + {4'd0, page_now} - 8'd1),
                     5'(COL_HI_CMD + {1'b0, c[7:4]}), c[3:0]};
    endfunction

    function automatic bit predict_glyph(input logic [7:0] b, input logic f,
                                         input logic [3:0] pg, input logic [7:0] cl,
                                         output t_glyph g);
        logic [7:0] lead;
        int unsigned idx;
        g = '0;
        if (f) begin
            page_now = pg;
            col_now = cl;
            lead_held = 1'b0;
            held_lead = '0;
            str_done = 1'b0;
        end else if (str_done) begin
            return 1'b0;
        end
        if (lead_held) begin
            lead = held_lead;
            lead_held = 1'b0;
            held_lead = '0;
            if (b >= TRAIL_LO) begin
                if (lead >= HANZI_LEAD_LO)
                    idx = (lead - HANZI_LEAD_LO) * ROW_SIZE + (b - TRAIL_LO) + HANZI_OFFSET;
                else
                    idx = (lead - SYM_LEAD_LO) * ROW_SIZE + (b - TRAIL_LO);
                g = glyph_of(ADDR_W'(idx * 32 + hanzi_base), 1'b1);
                col_now = col_now + WIDE_STEP;
                return 1'b1;
            end
        end
        if (b == TERMINATOR) begin
            str_done = 1'b1;
            return 1'b0;
        end
        if ((b >= HANZI_LEAD_LO && b <= HANZI_LEAD_HI) ||
            (b >= SYM_LEAD_LO && b <= SYM_LEAD_HI)) begin
            held_lead = b;
            lead_held = 1'b1;
            return 1'b0;
        end
        if (b >= ASCII_LO && b <= ASCII_HI) begin
            g = glyph_of(ADDR_W'((b - ASCII_LO) * 16 + ascii_base), 1'b0);
            col_now = col_now + NARROW_STEP;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // called at a rising edge; returns at the edge where the byte is taken
    task automatic push_text_byte(input logic [7:0] b, input logic f, input logic [3:0] pg,
                                  input logic [7:0] cl, input t_row_kind kind,
                                  input t_glyph typed);
        t_glyph g;
        bit got;
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        first_of_string <= f;
        start_page <= pg;
        start_column <= cl;
        do @(posedge i_clk); while (!in_ready);
        if (f || !str_done)
            live_bytes++;
        got = predict_glyph(b, f, pg, cl, g);
        case (kind)
            ROW_PRED: if (got) glyphs_due.push_back(g);
            ROW_GLYPH: glyphs_due.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic send_plain(input logic [7:0] b);
        logic f;
        f = open_string;
        open_string = 1'b0;
        push_text_byte(b, f, f ? string_page : 4'($urandom_range(0, 15)),
                       f ? string_column : 8'($urandom_range(0, 255)), ROW_PRED, '0);
    endtask

    task automatic send_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_plain(8'($urandom_range(ASCII_LO, ASCII_HI)));
        end else if (r < 65) begin
            send_plain(8'($urandom_range(HANZI_LEAD_LO, HANZI_LEAD_HI)));
            send_plain(8'($urandom_range(TRAIL_LO, 255)));
        end else if (r < 75) begin
            send_plain(8'($urandom_range(SYM_LEAD_LO, SYM_LEAD_HI)));
            send_plain(8'($urandom_range(TRAIL_LO, 255)));
        end else if (r < 83) begin
            // lead with no valid trail
            if (r[0])
                send_plain(8'($urandom_range(HANZI_LEAD_LO, HANZI_LEAD_HI)));
            else
                send_plain(8'($urandom_range(SYM_LEAD_LO, SYM_LEAD_HI)));
            send_plain(8'($urandom_range(0, TRAIL_LO - 1)));
        end else begin
            send_plain(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_strings(input int n_bytes, input bit calm);
        int target;
        target = live_bytes + n_bytes;
        while (live_bytes < target) begin
            if (calm) begin
                in_idle_on = 1'b0;
                out_idle_on = 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                in_idle_on = $urandom_range(0, 3) != 0;
                out_idle_on = $urandom_range(0, 3) != 0;
            end
            open_string = 1'b1;
            string_page = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 8));
            string_column = 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 12)) send_token();
            if ($urandom_range(0, 9) < 7) begin
                send_plain(TERMINATOR);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send_plain(8'($urandom_range(1, 255)));
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (glyphs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [ADDR_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= {8'($urandom_range(0, 255)), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == REG_HANZI_BASE)
            hanzi_base = v;
        else
            ascii_base = v;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_glyph got, want;
        if (i_rst_n && out_valid && out_ready) begin
            got = '{glyph_address, wide_glyph, glyph_column, page_command,
                    column_high_command, column_low_command};
            if (glyphs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected glyph word: addr %h wide %b col %0d page %h hi %h lo %h",
                             got.addr, got.wide, got.column, got.page_cmd, got.col_hi,
                             got.col_lo);
            end else begin
                want = glyphs_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("glyph mismatch: exp %h/%b/%0d/%h/%h/%h got %h/%b/%0d/%h/%h/%h",
                                 want.addr, want.wide, want.column, want.page_cmd,
                                 want.col_hi, want.col_lo, got.addr, got.wide, got.column,
                                 got.page_cmd, got.col_hi, got.col_lo);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (out_idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        script = '{
            '{8'h41, 1'b0, 4'd0,  8'd0,   ROW_NONE,  '0},
            '{8'h20, 1'b1, 4'd1,  8'd1,   ROW_GLYPH,
              '{24'h03CF80, 1'b0, 8'd1, 8'hB0, 5'h10, 4'h0}},
            '{8'h7E, 1'b0, 4'd0,  8'd0,   ROW_GLYPH,
              '{24'h03D560, 1'b0, 8'd9, 8'hB0, 5'h10, 4'h8}},
            '{8'h1F, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h7F, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hB0, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hA1, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hF7, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hFE, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hA1, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hA1, 1'b0, 4'd0,  8'd0,   ROW_GLYPH,
              '{24'h000000, 1'b1, 8'd49, 8'hB0, 5'h13, 4'h0}},
            '{8'hA3, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hFF, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hB5, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h41, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hC0, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h00, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hA1, 1'b0, 4'd0,  8'd0,   ROW_NONE,  '0},
            '{8'h41, 1'b1, 4'd0,  8'd0,   ROW_GLYPH,
              '{24'h03D190, 1'b0, 8'd0, 8'hAF, 5'h1F, 4'hF}},
            '{8'hD0, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h42, 1'b1, 4'd8,  8'd255, ROW_GLYPH,
              '{24'h03D1A0, 1'b0, 8'd255, 8'hB7, 5'h1F, 4'hE}},
            '{8'h43, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h80, 1'b1, 4'd15, 8'd240, ROW_PRED,  '0},
            '{8'hA2, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'hB0, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0},
            '{8'h7E, 1'b0, 4'd0,  8'd0,   ROW_PRED,  '0}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset base addresses in force
        for (int i = 0; i < 26; i++)
            push_text_byte(script[i].text, script[i].first, script[i].page,
                           script[i].column, script[i].kind, script[i].glyph);

        settle();
        write_reg(REG_HANZI_BASE, 24'hFFFFFF);
        write_reg(REG_ASCII_BASE, 24'hFFFFFF);
        run_strings(250, 1'b0);

        settle();
        write_reg(REG_HANZI_BASE, 24'h000000);
        write_reg(REG_ASCII_BASE, 24'h000000);
        run_strings(200, 1'b0);

        settle();
        write_reg(REG_HANZI_BASE, ADDR_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_ASCII_BASE, ADDR_W'($urandom_range(0, 24'hFFFFFF)));
        run_strings(200, 1'b0);

        settle();
        write_reg(REG_ASCII_BASE, ADDR_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_HANZI_BASE, ADDR_W'($urandom_range(0, 24'hFFFFFF)));
        run_strings(150, 1'b1);

        settle();
        if (glyphs_due.size() != 0) begin
            mismatches++;
            $display("%0d glyph words never arrived", glyphs_due.size());
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
